[rtl/a2b_pkg.sv]
// Shared types and constants for the decoder configuration record to
// Annex B converter. Used by every module of the block; no dependencies.
`default_nettype none

package a2b_pkg;

    localparam int LENGTH_BITS = 16;
    localparam logic [15:0] LEN_MASK = (LENGTH_BITS >= 16) ? 16'hFFFF
        : 16'((32'd1 << LENGTH_BITS) - 32'd1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic [15:0] MIN_RECORD_LEN = 16'd7;
    localparam logic [7:0] VERSION_ONE = 8'd1;
    localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;
    localparam logic [2:0] START_CODE_LEN = 3'd4;

    // Work that one accepted byte hands to the back end.
    typedef struct packed {
        logic       emit_sc;
        logic       emit_byte;
        logic [7:0] data;
        logic       emit_status;
        logic [1:0] status;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/a2b_front.sv]
// Front end: parses record bytes, holds the record length register and
// the parse state, and writes one command per byte that causes output.
// Depends on a2b_pkg.
`default_nettype none

module a2b_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           record_length_we,
    input  wire logic [15:0]    record_length,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     in_byte,
    input  wire logic           fifo_full,
    output logic                push,
    output a2b_pkg::cmd_t       push_cmd
);
    import a2b_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_SPS_COUNT,
        PH_PPS_COUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_DONE,
        PH_STOPPED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] total_reg;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  entries_reg, entries_next;
    logic [15:0] payload_reg, payload_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        pps_reg, pps_next;
    logic [1:0]  stop_reg, stop_next;

    logic        accept;
    logic        final_byte;
    logic [15:0] entry_len;
    logic [17:0] entry_end;
    logic [7:0]  entries_dec;
    logic        emit_sc;
    logic        emit_byte;
    logic [1:0]  status;

    assign accept = in_valid && !in_stall;
    assign in_stall = fifo_full;
    assign final_byte = ({1'b0, pos_reg} + 17'd1) == {1'b0, total_reg};
    assign entry_len = {len_hi_reg, in_byte} & LEN_MASK;
    assign entry_end = {2'b00, pos_reg} + 18'd1 + {2'b00, entry_len};
    assign entries_dec = entries_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        entries_next = entries_reg;
        payload_next = payload_reg;
        len_hi_next = len_hi_reg;
        pps_next = pps_reg;
        stop_next = stop_reg;
        pos_next = pos_reg + 16'd1;
        emit_sc = 1'b0;
        emit_byte = 1'b0;
        status = ST_OK;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == 16'd0)
                begin
                    if (total_reg < MIN_RECORD_LEN || in_byte != VERSION_ONE)
                    begin
                        phase_next = PH_STOPPED;
                        stop_next = ST_REJECT;
                    end
                end
                else if (pos_reg >= 16'd4)
                begin
                    phase_next = PH_SPS_COUNT;
                end
            end
            PH_SPS_COUNT:
            begin
                entries_next = in_byte & SPS_COUNT_MASK;
                pps_next = 1'b0;
                phase_next = ((in_byte & SPS_COUNT_MASK) != 8'd0) ? PH_LEN_HI
                                                                   : PH_PPS_COUNT;
            end
            PH_PPS_COUNT:
            begin
                entries_next = in_byte;
                pps_next = 1'b1;
                phase_next = (in_byte != 8'd0) ? PH_LEN_HI : PH_DONE;
            end
            PH_LEN_HI:
            begin
                len_hi_next = in_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if (entry_end > {2'b00, total_reg})
                begin
                    phase_next = PH_STOPPED;
                    stop_next = ST_TRUNC;
                end
                else
                begin
                    emit_sc = 1'b1;
                    if (entry_len == 16'd0)
                    begin
                        entries_next = entries_dec;
                        if (entries_dec == 8'd0)
                            phase_next = pps_reg ? PH_DONE : PH_PPS_COUNT;
                        else
                            phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        payload_next = entry_len;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit_byte = 1'b1;
                payload_next = payload_reg - 16'd1;
                if (payload_reg == 16'd1)
                begin
                    entries_next = entries_dec;
                    if (entries_dec == 8'd0)
                        phase_next = pps_reg ? PH_DONE : PH_PPS_COUNT;
                    else
                        phase_next = PH_LEN_HI;
                end
            end
            PH_DONE, PH_STOPPED:
            begin
            end
            default:
            begin
            end
        endcase

        // The status reflects where parsing stands after this byte.
        if (phase_next == PH_DONE)
            status = ST_OK;
        else if (phase_next == PH_STOPPED)
            status = stop_next;
        else
            status = ST_TRUNC;

        if (final_byte)
        begin
            phase_next = PH_HEADER;
            pos_next = 16'd0;
            entries_next = 8'd0;
            payload_next = 16'd0;
            len_hi_next = 8'd0;
            pps_next = 1'b0;
            stop_next = ST_OK;
        end
    end

    assign push = accept && (emit_sc || emit_byte || final_byte);
    assign push_cmd = '{
        emit_sc: emit_sc,
        emit_byte: emit_byte,
        data: in_byte,
        emit_status: final_byte,
        status: status
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            total_reg <= 16'd1;
            pos_reg <= 16'd0;
            entries_reg <= 8'd0;
            payload_reg <= 16'd0;
            len_hi_reg <= 8'd0;
            pps_reg <= 1'b0;
            stop_reg <= ST_OK;
        end
        else
        begin
            if (record_length_we)
                total_reg <= record_length;
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                entries_reg <= entries_next;
                payload_reg <= payload_next;
                len_hi_reg <= len_hi_next;
                pps_reg <= pps_next;
                stop_reg <= stop_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/a2b_fifo.sv]
// Short command queue between the parser and the output sequencer.
// Depends on a2b_pkg for the command type and depth.
`default_nettype none

module a2b_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire a2b_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output a2b_pkg::cmd_t       head_cmd,
    output logic                empty,
    output logic                full
);
    import a2b_pkg::*;

    cmd_t               slots_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign empty = (count_reg == '0);
    assign full = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_cmd = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + FIFO_AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + FIFO_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (FIFO_AW + 1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (FIFO_AW + 1)'(1);
        end
    end

endmodule

`default_nettype wire

[rtl/a2b_back.sv]
// Output sequencer: expands each queued command into start-code, payload
// and status transfers behind a registered output stage. Depends on a2b_pkg.
`default_nettype none

module a2b_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire a2b_pkg::cmd_t  head_cmd,
    input  wire logic           fifo_empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                is_start_code,
    output logic [1:0]          record_status,
    output logic                last
);
    import a2b_pkg::*;

    // Pieces of the command being expanded.
    logic       busy_reg;
    logic [2:0] sc_left_reg;
    logic       byte_pend_reg;
    logic [7:0] data_reg;
    logic       status_pend_reg;
    logic [1:0] status_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       is_sc_reg;
    logic [1:0] out_status_reg;
    logic       last_reg;

    logic       slot_free;
    logic       emit;
    logic [2:0] sc_left_next;
    logic       byte_pend_next;
    logic       status_pend_next;
    logic       done;

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit = busy_reg && slot_free;

    always_comb
    begin
        sc_left_next = sc_left_reg;
        byte_pend_next = byte_pend_reg;
        status_pend_next = status_pend_reg;
        if (sc_left_reg != 3'd0)
            sc_left_next = sc_left_reg - 3'd1;
        else if (byte_pend_reg)
            byte_pend_next = 1'b0;
        else
            status_pend_next = 1'b0;
    end

    assign done = (sc_left_next == 3'd0) && !byte_pend_next && !status_pend_next;
    assign pop = !fifo_empty && (!busy_reg || (emit && done));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sc_left_reg <= 3'd0;
            byte_pend_reg <= 1'b0;
            status_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A pop while busy only happens as the current command finishes.
            if (pop)
            begin
                busy_reg <= 1'b1;
                sc_left_reg <= head_cmd.emit_sc ? START_CODE_LEN : 3'd0;
                byte_pend_reg <= head_cmd.emit_byte;
                status_pend_reg <= head_cmd.emit_status;
            end
            else if (emit)
            begin
                sc_left_reg <= sc_left_next;
                byte_pend_reg <= byte_pend_next;
                status_pend_reg <= status_pend_next;
                if (done)
                    busy_reg <= 1'b0;
            end
            if (slot_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head_cmd.data;
            status_reg <= head_cmd.status;
        end
        if (emit)
        begin
            last_reg <= done;
            if (sc_left_reg != 3'd0)
            begin
                // The final start-code byte is the 01.
                out_byte_reg <= (sc_left_reg == 3'd1) ? 8'h01 : 8'h00;
                byte_valid_reg <= 1'b1;
                is_sc_reg <= 1'b1;
                out_status_reg <= ST_OK;
            end
            else if (byte_pend_reg)
            begin
                out_byte_reg <= data_reg;
                byte_valid_reg <= 1'b1;
                is_sc_reg <= 1'b0;
                out_status_reg <= ST_OK;
            end
            else
            begin
                out_byte_reg <= 8'h00;
                byte_valid_reg <= 1'b0;
                is_sc_reg <= 1'b0;
                out_status_reg <= status_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign is_start_code = is_sc_reg;
    assign record_status = out_status_reg;
    assign last = last_reg;

endmodule

`default_nettype wire

[rtl/avcc_to_annexb_param_sets_unit.sv]
// Converts a decoder configuration record into Annex B parameter sets.
// An input byte passes through the command queue, the sequencer's command
// registers and a registered output stage. One input byte is taken per cycle
// while the 4-entry command queue is not full; the output sequencer sends one
// transfer per cycle while out_stall is low; the queue absorbs 4-byte start codes.
// Reset is asynchronous, active low; it clears the parse state and the queue and
// sets record_length to 1.
`default_nettype none

module avcc_to_annexb_param_sets_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       record_length_we,
    input  wire logic [15:0] record_length,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            is_start_code,
    output logic [1:0]      record_status,
    output logic            last
);
    import a2b_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head_cmd;
    logic fifo_empty;
    logic fifo_full;

    a2b_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .record_length_we (record_length_we),
        .record_length    (record_length),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .fifo_full        (fifo_full),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    a2b_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    a2b_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .fifo_empty    (fifo_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .is_start_code (is_start_code),
        .record_status (record_status),
        .last          (last)
    );

endmodule

`default_nettype wire

[verif/avcc_to_annexb_param_sets_unit_tb.sv]
// Self-checking testbench for avcc_to_annexb_param_sets_unit: feeds decoder
// configuration records byte by byte and checks every Annex B transfer.
// Depends on a2b_pkg and the unit itself; nothing else.
`timescale 1ns / 1ps

module avcc_to_annexb_param_sets_unit_tb;
    import a2b_pkg::*;

    localparam int QUIET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 410;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS = 40;
    localparam int NO_HOLD = -1;

    localparam int REC_CLEAN = 0;
    localparam int REC_NOISE = 1;
    localparam int REC_BROKEN = 2;

    typedef enum logic [3:0] {
        PS_HDR, PS_SPS_CNT, PS_PPS_CNT, PS_LEN_HI, PS_LEN_LO, PS_PAYLOAD, PS_DONE, PS_STOPPED
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       data_flag;
        logic       sc;
        logic [1:0] st;
        logic       last;
    } annexb_out_t;

    typedef struct packed {
        logic        wr;
        logic [15:0] len;
        logic [7:0]  b;
        logic        typed;
        logic [1:0]  st;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        record_length_we = 1'b0;
    logic [15:0] record_length = 16'd1;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_start_code;
    logic [1:0]  record_status;
    logic        last;

    avcc_to_annexb_param_sets_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .record_length_we (record_length_we),
        .record_length    (record_length),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .byte_valid       (byte_valid),
        .is_start_code    (is_start_code),
        .record_status    (record_status),
        .last             (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser state as the converter should see it.
    parse_state_t cur_phase = PS_HDR;
    logic [15:0]  rec_pos = 16'd0;
    logic [7:0]   entries_to_go = 8'd0;
    logic [15:0]  payload_to_go = 16'd0;
    logic [7:0]   len_msb = 8'd0;
    logic         pps_section = 1'b0;
    logic [1:0]   stop_code = ST_OK;
    logic [15:0]  rec_len_reg = 16'd1;

    annexb_out_t expected_out[$];
    logic [7:0]  rec_bytes[$];
    int          gen_len;

    int mismatch_cnt = 0;
    int cycle_cnt = 0;
    int records_sent = 0;
    int bytes_sent = 0;
    int transfers_seen = 0;
    int start_codes_seen = 0;
    logic steady = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    dir_row_t dir_rows [0:25];

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic close_entry();
        entries_to_go = entries_to_go - 8'd1;
        if (entries_to_go == 8'd0)
            cur_phase = pps_section ? PS_DONE : PS_PPS_CNT;
        else
            cur_phase = PS_LEN_HI;
    endtask

    // Advances the parser by one byte and queues the transfers it causes.
    task automatic parse_record_byte(input logic [7:0] b, input logic keep);
        annexb_out_t step_q[$];
        annexb_out_t r;
        logic        at_end;
        logic [15:0] ent_len;
        logic [17:0] reach;
        logic [1:0]  st;
        at_end = ({1'b0, rec_pos} + 17'd1) == {1'b0, rec_len_reg};
        case (cur_phase)
            PS_HDR:
            begin
                if (rec_pos == 16'd0)
                begin
                    if (rec_len_reg < MIN_RECORD_LEN || b != VERSION_ONE)
                    begin
                        cur_phase = PS_STOPPED;
                        stop_code = ST_REJECT;
                    end
                end
                else if (rec_pos >= 16'd4)
                    cur_phase = PS_SPS_CNT;
            end
            PS_SPS_CNT:
            begin
                entries_to_go = b & SPS_COUNT_MASK;
                pps_section = 1'b0;
                cur_phase = (entries_to_go != 8'd0) ? PS_LEN_HI : PS_PPS_CNT;
            end
            PS_PPS_CNT:
            begin
                entries_to_go = b;
                pps_section = 1'b1;
                cur_phase = (entries_to_go != 8'd0) ? PS_LEN_HI : PS_DONE;
            end
            PS_LEN_HI:
            begin
                len_msb = b;
                cur_phase = PS_LEN_LO;
            end
            PS_LEN_LO:
            begin
                ent_len = {len_msb, b} & LEN_MASK;
                reach = 18'(rec_pos) + 18'd1 + 18'(ent_len);
                if (reach > 18'(rec_len_reg))
                begin
                    cur_phase = PS_STOPPED;
                    stop_code = ST_TRUNC;
                end
                else
                begin
                    for (int i = 0; i < int'(START_CODE_LEN); i++)
                    begin
                        r = '{data: (i == int'(START_CODE_LEN) - 1) ? 8'd1 : 8'd0,
                              data_flag: 1'b1, sc: 1'b1, st: ST_OK, last: 1'b0};
                        step_q = {step_q, r};
                    end
                    if (ent_len == 16'd0)
                        close_entry();
                    else
                    begin
                        payload_to_go = ent_len;
                        cur_phase = PS_PAYLOAD;
                    end
                end
            end
            PS_PAYLOAD:
            begin
                r = '{data: b, data_flag: 1'b1, sc: 1'b0, st: ST_OK, last: 1'b0};
                step_q = {step_q, r};
                payload_to_go = payload_to_go - 16'd1;
                if (payload_to_go == 16'd0)
                    close_entry();
            end
            default:
            begin
            end
        endcase
        rec_pos = rec_pos + 16'd1;
        if (at_end)
        begin
            if (cur_phase == PS_DONE)
                st = ST_OK;
            else if (cur_phase == PS_STOPPED)
                st = stop_code;
            else
                st = ST_TRUNC;
            r = '{data: 8'd0, data_flag: 1'b0, sc: 1'b0, st: st, last: 1'b0};
            step_q = {step_q, r};
            cur_phase = PS_HDR;
            rec_pos = 16'd0;
            entries_to_go = 8'd0;
            payload_to_go = 16'd0;
            len_msb = 8'd0;
            pps_section = 1'b0;
            stop_code = ST_OK;
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        if (keep)
            expected_out = {expected_out, step_q};
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [1:0] typed_st);
        annexb_out_t r;
        if (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_record_byte(b, !typed);
        if (typed)
        begin
            r = '{data: 8'd0, data_flag: 1'b0, sc: 1'b0, st: typed_st, last: 1'b1};
            expected_out = {expected_out, r};
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // The converter is idle once every expected transfer is out and the
    // pipeline has had time to finish bytes that produce nothing.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_record_length(input logic [15:0] v);
        record_length_we <= 1'b1;
        record_length <= v;
        @(negedge clk);
        record_length_we <= 1'b0;
        rec_len_reg = v;
    endtask

    task automatic add_byte(input logic [7:0] v);
        rec_bytes = {rec_bytes, v};
    endtask

    task automatic add_entries(input int count);
        int n;
        for (int e = 0; e < count; e++)
        begin
            n = ($urandom_range(99) < 3) ? $urandom_range(256, 300) : $urandom_range(0, 6);
            add_byte(8'(n >> 8));
            add_byte(8'(n));
            repeat (n) add_byte(8'($urandom));
        end
    endtask

    task automatic gen_record(input int kind);
        int sps;
        int pps;
        int idx;
        rec_bytes.delete();
        if (kind == REC_NOISE)
        begin
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
            gen_len = rec_bytes.size();
        end
        else
        begin
            add_byte(VERSION_ONE);
            repeat (4) add_byte(8'($urandom));
            sps = $urandom_range(0, 3);
            add_byte({3'($urandom), 5'(sps)});
            add_entries(sps);
            pps = $urandom_range(0, 3);
            add_byte(8'(pps));
            add_entries(pps);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            if (kind == REC_BROKEN)
            begin
                idx = $urandom_range(0, rec_bytes.size() - 1);
                rec_bytes[idx] = 8'($urandom);
            end
            gen_len = rec_bytes.size();
            if ($urandom_range(99) < 15)
                gen_len = $urandom_range(1, rec_bytes.size());
        end
    endtask

    task automatic send_record(input int len, input int hold_at);
        wait_quiet();
        write_record_length(16'(len));
        for (int i = 0; i < len; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            send_byte(rec_bytes[i], 1'b0, ST_OK);
        end
        records_sent++;
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !steady && ($urandom_range(99) < 7);
    end

    always @(posedge clk)
    begin : check_blk
        annexb_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            transfers_seen++;
            if (is_start_code)
                start_codes_seen++;
            if (expected_out.size() == 0)
                report_mismatch("transfer with nothing expected, out_byte", out_byte, -1);
            else
            begin
                want = expected_out.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (byte_valid !== want.data_flag)
                    report_mismatch("byte_valid", byte_valid, want.data_flag);
                if (is_start_code !== want.sc)
                    report_mismatch("is_start_code", is_start_code, want.sc);
                if (record_status !== want.st)
                    report_mismatch("record_status", record_status, want.st);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : main_blk
        int rec_idx;
        int kind;
        int guard;
        int cut;

        // Rows: write, length, byte, typed, status. Typed rows carry the status
        // transfer that must close the record on that byte.
        dir_rows = '{
            '{1'b0, 16'd0,  8'h01, 1'b1, ST_REJECT},  // reset length 1 is too short
            '{1'b1, 16'd7,  8'h00, 1'b0, ST_OK},      // bad version
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h80, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h7F, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h01, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h55, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h00, 1'b1, ST_REJECT},
            '{1'b1, 16'd7,  8'h01, 1'b0, ST_OK},      // both counts zero
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'hE0, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h00, 1'b1, ST_OK},
            '{1'b1, 16'd10, 8'h01, 1'b0, ST_OK},      // entry runs past the end
            '{1'b0, 16'd0,  8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h01, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd0,  8'h5A, 1'b1, ST_TRUNC},
            '{1'b1, 16'd1,  8'hFF, 1'b1, ST_REJECT}   // shortest length, written
        };

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr)
            begin
                wait_quiet();
                write_record_length(dir_rows[i].len);
                records_sent++;
            end
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].st);
        end

        // A length update in the middle of a record applies from the next byte.
        gen_record(REC_CLEAN);
        wait_quiet();
        write_record_length(16'(rec_bytes.size() + 5));
        cut = 3;
        for (int i = 0; i < cut; i++)
            send_byte(rec_bytes[i], 1'b0, ST_OK);
        wait_quiet();
        write_record_length(16'(rec_bytes.size()));
        for (int i = cut; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i], 1'b0, ST_OK);
        records_sent++;

        // Three full SPS entries and one PPS. The receiver holds off partway
        // through so the queue backs up.
        rec_bytes.delete();
        add_byte(VERSION_ONE);
        repeat (4) add_byte(8'($urandom));
        add_byte(8'hE3);
        repeat (3)
        begin
            add_byte(8'h00);
            add_byte(8'd20);
            repeat (20) add_byte(8'($urandom));
        end
        add_byte(8'h01);
        add_byte(8'h00);
        add_byte(8'h04);
        repeat (4) add_byte(8'($urandom));
        send_record(rec_bytes.size(), 10);

        rec_idx = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
                kind = REC_NOISE;
            else if (kind < 22)
                kind = REC_BROKEN;
            else
                kind = REC_CLEAN;
            gen_record(kind);
            steady = (rec_idx >= 5 && rec_idx < 10);
            send_record(gen_len, NO_HOLD);
            rec_idx++;
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        guard = 0;
        while (expected_out.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);
        if (expected_out.size() != 0)
            report_mismatch("expected transfers never seen", 0, expected_out.size());

        $display("Sent %0d records (%0d bytes), checked %0d transfers, %0d of them start code.",
                 records_sent, bytes_sent, transfers_seen, start_codes_seen);
        $display("Included rejected, truncated, mid-record length update and long hold-off cases.");
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/a2b_pkg.sv
rtl/a2b_front.sv
rtl/a2b_fifo.sv
rtl/a2b_back.sv
rtl/avcc_to_annexb_param_sets_unit.sv
verif/avcc_to_annexb_param_sets_unit_tb.sv
